// ===== rtl/ppfm_pkg.sv =====
// shared constants, types and codes of the pin pair fault monitor
package ppfm_pkg;

  localparam int PIN_COUNT   = 20;
  localparam int SAMPLE_BITS = 12;

  localparam int PAIR_SLOTS = PIN_COUNT * PIN_COUNT;
  localparam int SLOT_W     = $clog2(PAIR_SLOTS);

  localparam int ACT_W  = 2;
  localparam int PIN_W  = 5;
  localparam int RAW_W  = 12;
  localparam int TOL_W  = 12;
  localparam int THR_W  = 8;
  localparam int CNT_W  = 8;
  localparam int TOT_W  = 16;
  localparam int CMP_W  = (SAMPLE_BITS > TOL_W) ? SAMPLE_BITS : TOL_W;
  localparam int BASE_W = 8 * SAMPLE_BITS;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(100);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);

  // action codes
  localparam logic [ACT_W-1:0] ACT_BASE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TEST  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REARM = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR = 1'd1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  // even entries pin a, odd entries pin b, drive states in order
  typedef sample_t [7:0] sample_set_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [PIN_W-1:0] pin_a;
    logic [PIN_W-1:0] pin_b;
    logic [RAW_W-1:0] a_both_low;
    logic [RAW_W-1:0] b_both_low;
    logic [RAW_W-1:0] a_a_high;
    logic [RAW_W-1:0] b_a_high;
    logic [RAW_W-1:0] a_b_high;
    logic [RAW_W-1:0] b_b_high;
    logic [RAW_W-1:0] a_both_high;
    logic [RAW_W-1:0] b_both_high;
  } in_item_t;

  typedef struct packed {
    logic             pair_fault;
    logic [CNT_W-1:0] pair_count;
    logic [TOT_W-1:0] total_count;
    logic             trip;
    logic             tripped;
  } out_item_t;

endpackage

// ===== rtl/ppfm_if.sv =====
// valid/ready channel interfaces of the pin pair fault monitor
interface ppfm_in_if;
  import ppfm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppfm_out_if;
  import ppfm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppfm_cfg_if;
  import ppfm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ppfm_ram.sv =====
// single port synchronous ram, read first, registered read data
module ppfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 400
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ppfm_cmp.sv =====
// tolerance check of eight readings against their baselines
module ppfm_cmp (
  input  ppfm_pkg::sample_set_t          rd,
  input  ppfm_pkg::sample_set_t          base,
  input  logic [ppfm_pkg::TOL_W-1:0]     tol,
  output logic                           fault
);
  import ppfm_pkg::*;

  sample_t    diff [8];
  logic [7:0] over;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      diff[k] = (rd[k] > base[k]) ? (rd[k] - base[k]) : (base[k] - rd[k]);
      over[k] = CMP_W'(diff[k]) > CMP_W'(tol);
    end
  end

  assign fault = |over;

endmodule

// ===== rtl/pin_pair_fault_monitor.sv =====
// pin pair fault monitor top level: control sequencer, config and state memories
//
// in_ch beats carry one ordered pin pair and its eight readings with an action:
// store baseline, test against baseline or rearm. every input beat yields
// exactly one out_ch beat with the fault flag, pair count, total count, trip
// and tripped status. cfg_ch writes tolerance (index 0) and trip threshold
// (index 1); it is always ready and should only be used while idle.
// an item passes through accept, memory read, compare and write back, and output
// load in that order, one item at a time. the single port count and baseline
// memories are touched once per item, and a new item is taken only once the
// last one is loaded to the output. after reset the block sweeps both memories
// to zero, one slot a cycle, with in_ch.ready low. a trip starts the same sweep
// over the count memory only. out_ch holds its beat in a register; when the
// receiver stalls a finished result waits there and the next item is still
// taken and worked on up to its output load, where it waits for the register
// to free up.
module pin_pair_fault_monitor (
  input logic             clk,
  input logic             rst_n,
  ppfm_in_if.sink         in_ch,
  ppfm_out_if.source      out_ch,
  ppfm_cfg_if.sink        cfg_ch
);
  import ppfm_pkg::*;

  // sequencer states
  localparam logic [2:0] S_INIT = 3'd0;  // clear sweep after reset
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;  // count clear sweep after trip

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PAIR_SLOTS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;

  // config registers
  logic [TOL_W-1:0] tol_r;
  logic [THR_W-1:0] thr_r;

  // item registers
  in_item_t          item_r;
  logic [SLOT_W-1:0] slot_r;
  logic              pair_ok_r;

  // global state
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             tripped_r, tripped_nxt;

  // result staging and output register
  out_item_t res_r;
  logic      trip_r;
  out_item_t out_data_r;
  logic      out_valid_r;

  logic in_beat;
  logic out_load;

  // memory ports
  logic              mem_sweep;
  logic [SLOT_W-1:0] mem_addr;
  logic              base_we, cnt_we;
  sample_set_t       base_wdata, base_rdata;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

  // compare path
  sample_set_t      rd_set;
  logic             cmp_fault;
  logic             is_test;
  logic             fault;
  logic [CNT_W-1:0] cnt_new;
  logic             hit;
  out_item_t        res_nxt;

  logic in_pair_ok;

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_beat       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;
  assign out_load      = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // pins must differ and lie below the pin count, else the item is ignored
  assign in_pair_ok = (int'(in_ch.data.pin_a) < PIN_COUNT) &&
                      (int'(in_ch.data.pin_b) < PIN_COUNT) &&
                      (in_ch.data.pin_a != in_ch.data.pin_b);

  // ---------------------------------------------------------------------
  // config writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      thr_r <= THR_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TOL: tol_r <= cfg_ch.data[TOL_W-1:0];
        CFG_THR: thr_r <= cfg_ch.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // item capture, slot = pin_a * PIN_COUNT + pin_b
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_beat) begin
      item_r    <= in_ch.data;
      pair_ok_r <= in_pair_ok;
      slot_r    <= in_pair_ok
                   ? SLOT_W'(int'(in_ch.data.pin_a) * PIN_COUNT + int'(in_ch.data.pin_b))
                   : '0;
    end
  end

  // readings in the low SAMPLE_BITS bits
  always_comb begin
    rd_set[0] = SAMPLE_BITS'(item_r.a_both_low);
    rd_set[1] = SAMPLE_BITS'(item_r.b_both_low);
    rd_set[2] = SAMPLE_BITS'(item_r.a_a_high);
    rd_set[3] = SAMPLE_BITS'(item_r.b_a_high);
    rd_set[4] = SAMPLE_BITS'(item_r.a_b_high);
    rd_set[5] = SAMPLE_BITS'(item_r.b_b_high);
    rd_set[6] = SAMPLE_BITS'(item_r.a_both_high);
    rd_set[7] = SAMPLE_BITS'(item_r.b_both_high);
  end

  // ---------------------------------------------------------------------
  // state memories; the sequencer runs one item at a time, so a write back
  // always lands before the next item reads
  // ---------------------------------------------------------------------
  assign mem_sweep = (state_r == S_INIT) || (state_r == S_CLR);
  assign mem_addr  = mem_sweep ? clr_idx_r : slot_r;

  assign base_we    = (state_r == S_INIT) ||
                      ((state_r == S_CALC) && pair_ok_r && (item_r.action == ACT_BASE));
  assign base_wdata = (state_r == S_INIT) ? '0 : rd_set;

  // a trip clears every count with the sweep, so no write back then
  assign cnt_we    = mem_sweep || ((state_r == S_CALC) && is_test && !hit);
  assign cnt_wdata = mem_sweep ? '0 : cnt_new;

  ppfm_ram #(
    .WIDTH (BASE_W),
    .DEPTH (PAIR_SLOTS)
  ) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .addr  (mem_addr),
    .wdata (base_wdata),
    .rdata (base_rdata)
  );

  ppfm_ram #(
    .WIDTH (CNT_W),
    .DEPTH (PAIR_SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (mem_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  ppfm_cmp u_cmp (
    .rd    (rd_set),
    .base  (base_rdata),
    .tol   (tol_r),
    .fault (cmp_fault)
  );

  // ---------------------------------------------------------------------
  // read-modify-write of the pair count, total and trip status
  // ---------------------------------------------------------------------
  always_comb begin
    is_test = pair_ok_r && (item_r.action == ACT_TEST) && !tripped_r;
    fault   = is_test && cmp_fault;
    cnt_new = fault ? (cnt_rdata + CNT_W'(1)) : cnt_rdata;
    hit     = is_test && (cnt_new >= thr_r);

    total_nxt = total_r;
    if (fault && (total_r != TOTAL_MAX)) begin
      total_nxt = total_r + TOT_W'(1);
    end
    if (hit) begin
      total_nxt = '0;
    end

    tripped_nxt = tripped_r;
    if (hit) begin
      tripped_nxt = 1'b1;
    end else if (pair_ok_r && (item_r.action == ACT_REARM)) begin
      tripped_nxt = 1'b0;
    end

    res_nxt.pair_fault  = fault;
    res_nxt.pair_count  = (!pair_ok_r || hit) ? '0 : cnt_new;
    res_nxt.total_count = total_nxt;
    res_nxt.trip        = hit;
    res_nxt.tripped     = tripped_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      tripped_r <= 1'b0;
      trip_r    <= 1'b0;
    end else if (state_r == S_CALC) begin
      total_r   <= total_nxt;
      tripped_r <= tripped_nxt;
      trip_r    <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CALC) begin
      res_r <= res_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      S_INIT, S_CLR: begin
        if (clr_idx_r == LAST_SLOT) begin
          clr_idx_nxt = '0;
          state_nxt   = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + SLOT_W'(1);
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_CALC;
      S_CALC: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = trip_r ? S_CLR : S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

endmodule

// ===== rtl/ppfm_chk.sv =====
// port level checker of the pin pair fault monitor and its bind
module ppfm_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ppfm_pkg::out_item_t out_data
);
  import ppfm_pkg::*;

  // the memory clear sweep follows reset, so no input beat right after it
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // one item at a time: an input beat closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready in the cycle after an input beat");

  // a tripping result comes with the count clear sweep running
  a_trip_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_data.trip |-> !in_ready)
    else $error("input ready while a trip result appears");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind pin_pair_fault_monitor ppfm_chk u_ppfm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ===== verif/tb.sv =====
// self-checking testbench for the pin pair fault monitor: directed plan and random phases
`timescale 1ns / 1ps

module tb;
  import ppfm_pkg::*;

  // action code the block has no use for, it must leave all state alone
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  always #4 clk = ~clk;

  ppfm_in_if  in_ch ();
  ppfm_out_if out_ch ();
  ppfm_cfg_if cfg_ch ();

  pin_pair_fault_monitor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // one step of the directed plan: either a register update or one input beat
  typedef struct {
    bit                    is_cfg;
    logic [TOL_W-1:0]      tol;
    logic [CFG_DATA_W-1:0] thr;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
  } plan_row_t;

  // shadow copy of the monitor state, kept in step with accepted input beats
  logic [RAW_W-1:0] base_mem [PAIR_SLOTS][8];
  logic [CNT_W-1:0] cnt_mem  [PAIR_SLOTS];
  logic [TOT_W-1:0] total_now;
  logic             tripped_now;
  logic [TOL_W-1:0] tol_now;
  logic [THR_W-1:0] thr_now;

  out_item_t pending_results [$];
  plan_row_t plan [$];
  int        fails = 0;
  bit        steady = 1'b0;

  // works out the result beat of one item and advances the shadow state
  function automatic out_item_t monitor_step(input in_item_t it);
    logic [RAW_W-1:0] rd [8];
    int               slot;
    int               diff;
    int               k;
    bit               fault;
    bit               trip_now;
    out_item_t        res;
    rd[0] = it.a_both_low;
    rd[1] = it.b_both_low;
    rd[2] = it.a_a_high;
    rd[3] = it.b_a_high;
    rd[4] = it.a_b_high;
    rd[5] = it.b_b_high;
    rd[6] = it.a_both_high;
    rd[7] = it.b_both_high;
    fault    = 1'b0;
    trip_now = 1'b0;
    res      = '0;
    if (it.pin_a < PIN_COUNT && it.pin_b < PIN_COUNT && it.pin_a != it.pin_b) begin
      slot = int'(it.pin_a) * PIN_COUNT + int'(it.pin_b);
      if (it.action == ACT_BASE) begin
        for (k = 0; k < 8; k++) base_mem[slot][k] = rd[k];
      end else if (it.action == ACT_TEST && !tripped_now) begin
        for (k = 0; k < 8; k++) begin
          diff = int'(rd[k]) - int'(base_mem[slot][k]);
          if (diff < 0) diff = -diff;
          if (diff > int'(tol_now)) fault = 1'b1;
        end
        if (fault) begin
          cnt_mem[slot] = cnt_mem[slot] + 8'd1;
          if (total_now != TOTAL_MAX) total_now = total_now + 16'd1;
        end
        // a zero threshold trips on every test, fault or not
        if (int'(cnt_mem[slot]) >= int'(thr_now)) begin
          trip_now    = 1'b1;
          tripped_now = 1'b1;
          total_now   = '0;
          foreach (cnt_mem[i]) cnt_mem[i] = '0;
        end
      end else if (it.action == ACT_REARM) begin
        tripped_now = 1'b0;
      end
      res.pair_count = cnt_mem[slot];
    end
    res.pair_fault  = fault;
    res.total_count = total_now;
    res.trip        = trip_now;
    res.tripped     = tripped_now;
    return res;
  endfunction

  function automatic in_item_t build_item(input logic [ACT_W-1:0] act, input int pa,
                                          input int pb, input logic [RAW_W-1:0] rd [8]);
    in_item_t it;
    it.action      = act;
    it.pin_a       = PIN_W'(pa);
    it.pin_b       = PIN_W'(pb);
    it.a_both_low  = rd[0];
    it.b_both_low  = rd[1];
    it.a_a_high    = rd[2];
    it.b_a_high    = rd[3];
    it.a_b_high    = rd[4];
    it.b_b_high    = rd[5];
    it.a_both_high = rd[6];
    it.b_both_high = rd[7];
    return it;
  endfunction

  // all eight readings at one level
  function automatic in_item_t flat_item(input logic [ACT_W-1:0] act, input int pa,
                                         input int pb, input logic [RAW_W-1:0] level);
    logic [RAW_W-1:0] rd [8];
    int               k;
    for (k = 0; k < 8; k++) rd[k] = level;
    return build_item(act, pa, pb, rd);
  endfunction

  function automatic out_item_t outcome(input bit f, input int c, input int t,
                                        input bit tr, input bit td);
    out_item_t r;
    r.pair_fault  = f;
    r.pair_count  = CNT_W'(c);
    r.total_count = TOT_W'(t);
    r.trip        = tr;
    r.tripped     = td;
    return r;
  endfunction

  task automatic step_row(input in_item_t it, input bit typed, input out_item_t want);
    plan.push_back('{1'b0, '0, '0, it, typed, want});
  endtask

  task automatic cfg_row(input logic [TOL_W-1:0] tol, input logic [CFG_DATA_W-1:0] thr);
    plan.push_back('{1'b1, tol, thr, '0, 1'b0, '0});
  endtask

  // drive one input beat, with a random gap ahead of it outside steady stretches, and queue its result
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    if (!steady)
      while ($urandom_range(99) < 30) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = monitor_step(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // drop valid, wait for every queued result, then wait on for a margin
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // both registers, back to back beats, only once the block has gone quiet
  task automatic set_config(input logic [TOL_W-1:0] tol, input logic [CFG_DATA_W-1:0] thr);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_TOL;
    cfg_ch.data  <= CFG_DATA_W'(tol);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tol_now = tol;
    cfg_ch.index <= CFG_THR;
    cfg_ch.data  <= thr;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    // only the low byte of the write lands in the threshold
    thr_now = thr[THR_W-1:0];
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  // receiver stalls about 30% of cycles, except during steady stretches
  always @(posedge clk) out_ch.ready <= steady || ($urandom_range(99) >= 30);

  // every accepted result beat is held against the oldest pending expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_ch.data);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("pair_fault", want.pair_fault, out_ch.data.pair_fault);
        check_field("pair_count", want.pair_count, out_ch.data.pair_count);
        check_field("total_count", want.total_count, out_ch.data.total_count);
        check_field("trip", want.trip, out_ch.data.trip);
        check_field("tripped", want.tripped, out_ch.data.tripped);
      end
    end
  end

  // hard stop in case the block hangs a handshake
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int               pa;
    int               pb;
    int               slot;
    int               k;
    int               v;
    int               t;
    int               pick;
    int               roll;
    int               sel;
    int               counted;
    int               phase;
    int               pool_a [4];
    int               pool_b [4];
    logic [RAW_W-1:0] rd [8];
    in_item_t         it;
    logic [ACT_W-1:0] act;
    logic [TOL_W-1:0] tol_pick;
    logic [THR_W-1:0] thr_pick;
    bit               live;

    // shadow state matches the block right after reset
    for (slot = 0; slot < PAIR_SLOTS; slot++) begin
      cnt_mem[slot] = '0;
      for (k = 0; k < 8; k++) base_mem[slot][k] = '0;
    end
    total_now   = '0;
    tripped_now = 1'b0;
    tol_now     = TOL_RESET;
    thr_now     = THR_RESET;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan, first block runs on the reset tolerance of 100 and threshold of 50
    // baselines start at zero, so a zero test is clean and a full-scale one is a fault
    step_row(flat_item(ACT_TEST, 0, 1, 12'd0), 1'b1, outcome(0, 0, 0, 0, 0));
    step_row(flat_item(ACT_TEST, 0, 1, 12'd4095), 1'b1, outcome(1, 1, 1, 0, 0));
    // a difference equal to the tolerance still passes, one more fails
    step_row(flat_item(ACT_TEST, 0, 1, 12'd100), 1'b1, outcome(0, 1, 1, 0, 0));
    it = flat_item(ACT_TEST, 0, 1, 12'd0);
    it.b_both_high = 12'd101;
    step_row(it, 1'b1, outcome(1, 2, 2, 0, 0));
    // equal pins and pins past the last one are ignored
    step_row(flat_item(ACT_TEST, 3, 3, 12'd4095), 1'b1, outcome(0, 0, 2, 0, 0));
    step_row(flat_item(ACT_TEST, 31, 0, 12'd4095), 1'b1, outcome(0, 0, 2, 0, 0));
    step_row(flat_item(ACT_TEST, 19, 20, 12'd4095), 1'b1, outcome(0, 0, 2, 0, 0));
    // spare action code leaves state alone but shows the pair count
    step_row(flat_item(ACT_SPARE, 0, 1, 12'd4095), 1'b1, outcome(0, 2, 2, 0, 0));
    step_row(flat_item(ACT_BASE, 19, 18, 12'd4095), 1'b1, outcome(0, 0, 2, 0, 0));
    step_row(flat_item(ACT_TEST, 19, 18, 12'd4095), 1'b1, outcome(0, 0, 2, 0, 0));
    step_row(flat_item(ACT_TEST, 19, 18, 12'd0), 1'b1, outcome(1, 1, 3, 0, 0));
    // rearm while not tripped is harmless
    step_row(flat_item(ACT_REARM, 0, 1, 12'd0), 1'b1, outcome(0, 2, 3, 0, 0));
    // the reversed pair is a slot of its own
    step_row(flat_item(ACT_BASE, 1, 0, 12'd4095), 1'b1, outcome(0, 0, 3, 0, 0));
    step_row(flat_item(ACT_TEST, 0, 1, 12'd0), 1'b1, outcome(0, 2, 3, 0, 0));
    for (k = 0; k < 8; k++) rd[k] = RAW_W'($urandom);
    step_row(build_item(ACT_BASE, 5, 6, rd), 1'b0, '0);
    for (k = 0; k < 8; k++) rd[k] = RAW_W'($urandom);
    step_row(build_item(ACT_TEST, 5, 6, rd), 1'b0, '0);
    // zero tolerance and a threshold of one: the first fault trips
    cfg_row(12'd0, 12'd1);
    step_row(flat_item(ACT_TEST, 2, 3, 12'd1), 1'b1, outcome(1, 0, 0, 1, 1));
    // tripped: tests are ignored, baselines still land, rearm needs a valid pair
    step_row(flat_item(ACT_TEST, 0, 1, 12'd4095), 1'b1, outcome(0, 0, 0, 0, 1));
    step_row(flat_item(ACT_BASE, 2, 3, 12'd7), 1'b1, outcome(0, 0, 0, 0, 1));
    step_row(flat_item(ACT_REARM, 4, 4, 12'd0), 1'b1, outcome(0, 0, 0, 0, 1));
    step_row(flat_item(ACT_REARM, 2, 3, 12'd0), 1'b1, outcome(0, 0, 0, 0, 0));
    step_row(flat_item(ACT_TEST, 2, 3, 12'd7), 1'b1, outcome(0, 0, 0, 0, 0));
    // widest tolerance, threshold write whose low byte is zero: every test trips
    cfg_row(12'd4095, 12'hF00);
    step_row(flat_item(ACT_TEST, 7, 8, 12'd4095), 1'b1, outcome(0, 0, 0, 1, 1));
    step_row(flat_item(ACT_REARM, 7, 8, 12'd0), 1'b1, outcome(0, 0, 0, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_config(plan[i].tol, plan[i].thr);
      else push_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    // random phases, each on its own register setting and a small pool of pairs
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          tol_pick = TOL_W'($urandom_range(300));
          thr_pick = THR_W'($urandom_range(6, 2));
        end
        1: begin
          tol_pick = '0;
          thr_pick = THR_W'(1);
        end
        2: begin
          tol_pick = '1;
          thr_pick = '1;
        end
        3: begin
          tol_pick = TOL_W'($urandom_range(4095));
          thr_pick = THR_W'($urandom_range(255, 1));
        end
        default: begin
          tol_pick = TOL_W'($urandom_range(200, 50));
          thr_pick = THR_W'($urandom_range(10, 3));
        end
      endcase
      // junk in the unused upper bits of the threshold write
      set_config(tol_pick, {4'($urandom_range(15)), thr_pick});
      for (k = 0; k < 4; k++) begin
        pool_a[k] = $urandom_range(PIN_COUNT - 1);
        pool_b[k] = (pool_a[k] + 1 + $urandom_range(PIN_COUNT - 2)) % PIN_COUNT;
      end
      // first phase runs with no idling on either side
      steady  = (phase == 0);
      counted = 0;
      while (counted < 80) begin
        roll = $urandom_range(99);
        sel  = $urandom_range(3);
        pa   = pool_a[sel];
        pb   = pool_b[sel];
        slot = pa * PIN_COUNT + pb;
        for (k = 0; k < 8; k++) rd[k] = RAW_W'($urandom);
        if (roll < 12) begin
          // noise: any action, any pin codes, any readings
          it = build_item(ACT_W'($urandom_range(3)), $urandom_range(31), $urandom_range(31), rd);
        end else if (roll < 26) begin
          it = build_item(ACT_BASE, pa, pb, rd);
        end else if (roll < 30 || (tripped_now && roll < 65)) begin
          it = build_item(ACT_REARM, pa, pb, rd);
        end else begin
          // test readings scattered around the baseline, some right at the tolerance edge
          t = int'(tol_now);
          for (k = 0; k < 8; k++) begin
            pick = $urandom_range(9);
            if (pick == 0) v = $urandom_range(4095);
            else if (pick == 1)
              v = int'(base_mem[slot][k]) + ($urandom_range(1) ? 1 : -1) * (t + int'($urandom_range(1)));
            else v = int'(base_mem[slot][k]) + int'($urandom_range(2 * t)) - t;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            rd[k] = RAW_W'(v);
          end
          it = build_item(ACT_TEST, pa, pb, rd);
        end
        // only items the block acts on count toward the phase
        act  = it.action;
        live = it.pin_a < PIN_COUNT && it.pin_b < PIN_COUNT && it.pin_a != it.pin_b &&
               act != ACT_SPARE && !(act == ACT_TEST && tripped_now);
        push_item(it, 1'b0, '0);
        if (live) counted++;
      end
    end
    steady = 1'b0;

    settle();
    repeat (16) @(posedge clk);
    fails += pending_results.size();
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ppfm_pkg.sv
rtl/ppfm_if.sv
rtl/ppfm_ram.sv
rtl/ppfm_cmp.sv
rtl/pin_pair_fault_monitor.sv
rtl/ppfm_chk.sv
verif/tb.sv
